FILE: rtl/core/pitr_pkg.sv
// Package for the polyphase interpolator with timing recovery.
// Holds payload structs, register indexes and default sizes; no dependencies.
package pitr_pkg;

  localparam int unsigned DefaultTaps   = 16;
  localparam int unsigned DefaultPhases = 32;
  localparam int unsigned EvalBudget    = 64;
  localparam int unsigned PhaseW        = 20;
  localparam int unsigned RateW         = 17;
  localparam int unsigned ValueW        = 24;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned CfgDataW      = 16;

  localparam logic [CfgIdxW-1:0] RegInRate     = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOutRate    = 2'd1;
  localparam logic [CfgIdxW-1:0] RegPhaseNudge = 2'd2;

  localparam logic ActSample = 1'b0;
  localparam logic ActCoef   = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [15:0] sample;
    logic        [5:0]  coef_phase;
    logic        [3:0]  coef_tap;
    logic signed [15:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    logic                     last;
  } out_item_t;

endpackage

FILE: rtl/core/pitr_div.sv
// Restoring divider, one quotient bit per cycle, for the phase to row mapping.
// Depends on nothing but its parameters.
module pitr_div #(
  parameter int unsigned NumW = 25,
  parameter int unsigned DenW = 17
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);

  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [DenW:0]   trial;

  assign trial = {rem_q, num_q[NumW-1]};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    if (start_i) begin
      num_d  = num_i;
      rem_d  = '0;
      cnt_d  = CntW'(NumW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_i}) begin
        rem_d = DenW'(trial - {1'b0, den_i});
        num_d = {num_q[NumW-2:0], 1'b1};
      end else begin
        rem_d = trial[DenW-1:0];
        num_d = {num_q[NumW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1));
  assign quot_o = num_d;

endmodule

FILE: rtl/core/polyphase_interpolator_timing_recovery.sv
// Top level of the polyphase interpolator with bit-transition timing recovery.
// Uses pitr_pkg and instantiates the divider pitr_div.
//
// Channel  Direction  Handshake            Payload
// in       input      in_valid / stall     in_item_t
// out      output     out_valid / stall    out_item_t
// cfg      input      cfg_valid / ready    index, data
//
// A coefficient write, or a sample before the window fills, leaves the block idle.
// Each evaluation runs the divider bit by bit, then one read, multiply and
// accumulate step per tap; there are up to 64 evaluations per sample.
// Reset clears control state; window and coefficient store hold no reset value.
// A stalled output holds the sequencer only when a further result must be moved.
module polyphase_interpolator_timing_recovery
  import pitr_pkg::*;
#(
  parameter int unsigned TAPS   = DefaultTaps,
  parameter int unsigned PHASES = DefaultPhases
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned RowW   = $clog2(PHASES + 1);
  localparam int unsigned NumW   = RateW + RowW;
  localparam int unsigned IdxW   = $clog2(TAPS);
  localparam int unsigned FillW  = $clog2(TAPS + 1);
  localparam int unsigned Depth  = (PHASES + 1) * TAPS;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned AccW   = 33 + $clog2(TAPS);
  localparam int unsigned EvalW  = $clog2(EvalBudget + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_CHK  = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_RD   = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_ACC  = 8'b0010_0000,
    S_EVAL = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [15:0]        in_rate_q, sym_rate_q;
  logic [7:0]         nudge_q;
  logic [PhaseW-1:0]  phase_q, phase_d;
  logic [FillW-1:0]   fill_q, fill_d;
  logic [EvalW-1:0]   eval_q, eval_d;
  logic               tog_q, tog_d, pb_q, pb_d, ppb_q, ppb_d;
  logic [RowW-1:0]    row_q, row_d;
  logic [IdxW-1:0]    idx_q, idx_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [31:0] prod_q;
  logic signed [15:0] rd_q;
  logic signed [15:0] win_q [TAPS];
  logic signed [15:0] mem [Depth];
  logic               pend_q, pend_d, ov_q, ov_d;
  logic signed [ValueW-1:0] pend_val_q, pend_val_d;
  out_item_t          out_q, out_d;

  logic [RateW-1:0]   rate;
  logic               accept, out_free, full_now, loop_go, bit_now, coef_ok;
  logic               div_start, div_done;
  logic [NumW-1:0]    div_quot, div_num;
  logic [AddrW-1:0]   rd_addr, wr_addr;
  logic [PhaseW-1:0]  ph_n;
  logic signed [AccW-16:0] shifted;
  logic signed [ValueW-1:0] sat_val;

  assign rate        = {sym_rate_q, 1'b0};
  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_free    = !ov_q || !out_stall_i;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;
  assign loop_go     = (phase_q < PhaseW'(rate)) && (eval_q < EvalW'(EvalBudget));
  assign bit_now     = (acc_q > 0);
  assign full_now    = (fill_d == FillW'(TAPS));
  assign coef_ok     = (int'(in_data_i.coef_phase) <= PHASES) &&
                       (int'(in_data_i.coef_tap) < TAPS);
  assign div_start   = (state_q == S_CHK) && loop_go;
  assign div_num     = NumW'(PHASES) * NumW'(phase_q[RateW-1:0]);
  assign rd_addr     = AddrW'(row_q) * AddrW'(TAPS) + AddrW'(idx_q);
  assign wr_addr     = AddrW'(in_data_i.coef_phase) * AddrW'(TAPS) +
                       AddrW'(in_data_i.coef_tap);
  assign shifted     = acc_q[AccW-1:15];

  always_comb begin
    if (int'(shifted) > 8388607) begin
      sat_val = 24'sh7FFFFF;
    end else if (int'(shifted) < -8388608) begin
      sat_val = -24'sh800000;
    end else begin
      sat_val = ValueW'(shifted);
    end
  end

  always_comb begin
    ph_n = phase_q;
    if (tog_q && (ppb_q != bit_now)) begin
      if (pb_q == bit_now) begin
        if (phase_q > 0) begin
          ph_n = (phase_q > PhaseW'(nudge_q)) ? phase_q - PhaseW'(nudge_q) : '0;
        end
      end else if ((phase_q + 1'b1) < PhaseW'(rate)) begin
        ph_n = phase_q + PhaseW'(nudge_q);
      end
    end
  end

  pitr_div #(
    .NumW(NumW),
    .DenW(RateW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (rate),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    fill_d     = (fill_q < FillW'(TAPS)) ? fill_q + 1'b1 : fill_q;
    eval_d     = eval_q;
    tog_d      = tog_q;
    pb_d       = pb_q;
    ppb_d      = ppb_q;
    row_d      = row_q;
    idx_d      = idx_q;
    acc_d      = acc_q;
    pend_d     = pend_q;
    pend_val_d = pend_val_q;
    ov_d       = ov_q && out_stall_i;
    out_d      = out_q;
    unique case (state_q)
      S_IDLE: begin
        if (!(accept && in_data_i.action == ActSample)) begin
          fill_d = fill_q;
        end
        if (accept && in_data_i.action == ActSample && full_now) begin
          eval_d  = '0;
          state_d = S_CHK;
          if (phase_q >= PhaseW'(rate)) begin
            phase_d = phase_q - PhaseW'(rate);
          end
        end
      end
      S_CHK: begin
        fill_d  = fill_q;
        state_d = loop_go ? S_DIV : S_FIN;
      end
      S_DIV: begin
        fill_d = fill_q;
        if (div_done) begin
          row_d   = RowW'(PHASES) - div_quot[RowW-1:0];
          idx_d   = '0;
          acc_d   = '0;
          state_d = S_RD;
        end
      end
      S_RD: begin
        fill_d  = fill_q;
        state_d = S_MUL;
      end
      S_MUL: begin
        fill_d  = fill_q;
        state_d = S_ACC;
      end
      S_ACC: begin
        fill_d  = fill_q;
        acc_d   = acc_q + AccW'(prod_q);
        if (idx_q == IdxW'(TAPS - 1)) begin
          state_d = S_EVAL;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_RD;
        end
      end
      S_EVAL: begin
        fill_d = fill_q;
        if (!(tog_q && pend_q && !out_free)) begin
          if (tog_q) begin
            if (pend_q) begin
              ov_d        = 1'b1;
              out_d.value = pend_val_q;
              out_d.last  = 1'b0;
            end
            pend_d     = 1'b1;
            pend_val_d = sat_val;
          end
          ppb_d   = pb_q;
          pb_d    = bit_now;
          tog_d   = !tog_q;
          phase_d = ph_n + PhaseW'(in_rate_q);
          eval_d  = eval_q + 1'b1;
          state_d = S_CHK;
        end
      end
      S_FIN: begin
        fill_d = fill_q;
        if (!pend_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          ov_d        = 1'b1;
          out_d.value = pend_val_q;
          out_d.last  = 1'b1;
          pend_d      = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_rate_q  <= 16'd1;
      sym_rate_q <= 16'd1;
      nudge_q    <= 8'd25;
      phase_q    <= '0;
      fill_q     <= '0;
      eval_q     <= '0;
      tog_q      <= 1'b0;
      pb_q       <= 1'b0;
      ppb_q      <= 1'b0;
      pend_q     <= 1'b0;
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      fill_q  <= fill_d;
      eval_q  <= eval_d;
      tog_q   <= tog_d;
      pb_q    <= pb_d;
      ppb_q   <= ppb_d;
      pend_q  <= pend_d;
      ov_q    <= ov_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegInRate:     in_rate_q  <= cfg_data_i;
          RegOutRate:    sym_rate_q <= cfg_data_i;
          RegPhaseNudge: nudge_q    <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    row_q      <= row_d;
    idx_q      <= idx_d;
    acc_q      <= acc_d;
    pend_val_q <= pend_val_d;
    out_q      <= out_d;
    prod_q     <= rd_q * win_q[idx_q];
    if (accept && in_data_i.action == ActSample) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        win_q[i] <= win_q[i + 1];
      end
      win_q[TAPS - 1] <= in_data_i.sample;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && in_data_i.action == ActCoef && coef_ok) begin
      mem[wr_addr] <= in_data_i.coef_value;
    end
    rd_q <= mem[rd_addr];
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_q)
    else $error("Result left pending while idle.");
  a_budget: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eval_q <= EvalW'(EvalBudget))
    else $error("Evaluation count exceeded its budget.");
  a_row_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |-> (row_q >= RowW'(1) && row_q <= RowW'(PHASES)))
    else $error("Coefficient row out of range.");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(out_q)))
    else $error("Stalled result was overwritten.");
`endif

endmodule

FILE: bench/testbench.sv
// Self-checking bench for polyphase_interpolator_timing_recovery.
// Loads the tap table and sweeps the rate registers, with random samples and
// random stalls, and checks each result against an in-bench prediction. Uses pitr_pkg.
`timescale 1ns / 1ps

module testbench;
  import pitr_pkg::*;

  localparam int unsigned NTaps = DefaultTaps;
  localparam int unsigned NPhases = DefaultPhases;
  localparam int unsigned DrainCycles = 6000;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  in_item_t            in_data_i;
  logic                out_valid_o;
  logic                out_stall_i;
  out_item_t           out_data_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  polyphase_interpolator_timing_recovery uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o(out_data_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  in_item_t  request_queue[$];
  out_item_t expected_results[$];
  logic signed [15:0] tap_table[NPhases+1][NTaps];
  logic signed [15:0] window[NTaps];
  int unsigned fill_level;
  int unsigned phase;
  bit toggle;
  bit last_bit;
  bit older_bit;
  int unsigned in_rate;
  int unsigned sym_rate;
  int unsigned nudge;
  bit offering;
  bit calm;
  bit hold_req;
  int hold_count;
  int errors;
  int samples_sent;
  int results_seen;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void interpolate(in_item_t item);
    int unsigned span;
    int unsigned row;
    int evals;
    int produced;
    longint acc;
    longint scaled;
    bit cur_bit;
    out_item_t res;
    if (item.action == ActCoef) begin
      if (item.coef_phase <= NPhases) tap_table[item.coef_phase][item.coef_tap] = item.coef_value;
      return;
    end
    for (int i = 0; i < NTaps - 1; i++) window[i] = window[i+1];
    window[NTaps-1] = item.sample;
    if (fill_level < NTaps) fill_level++;
    if (fill_level < NTaps) return;
    span = 2 * sym_rate;
    evals = 0;
    produced = 0;
    if (phase >= span) phase -= span;
    while (phase < span && evals < EvalBudget) begin
      row = NPhases - (NPhases * phase) / span;
      evals++;
      acc = 0;
      for (int i = 0; i < NTaps; i++) acc += longint'(tap_table[row][i]) * longint'(window[i]);
      cur_bit = acc > 0;
      if (toggle) begin
        scaled = acc >>> 15;
        if (scaled > 8388607) scaled = 8388607;
        if (scaled < -8388608) scaled = -8388608;
        res.value = scaled[ValueW-1:0];
        res.last = 1'b0;
        expected_results.push_back(res);
        produced++;
        if (older_bit != cur_bit) begin
          if (last_bit == cur_bit) begin
            if (phase > 0) phase = phase > nudge ? phase - nudge : 0;
          end else if (phase + 1 < span) begin
            phase += nudge;
          end
        end
      end
      older_bit = last_bit;
      last_bit = cur_bit;
      toggle = ~toggle;
      phase = (phase + in_rate) & 32'hFFFFF;
    end
    if (produced > 0) expected_results[$].last = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      interpolate(in_data_i);
      if (in_data_i.action == ActSample) samples_sent++;
      void'(request_queue.pop_front());
      offering = 1'b0;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && !offering && request_queue.size() > 0 &&
        (calm || $urandom_range(99) >= 24)) begin
      offering = 1'b1;
      in_data_i <= request_queue[0];
    end
    in_valid_i <= offering;
  end

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d last=%0b", $realtime,
                 out_data_o.value, out_data_o.last);
      end else begin
        if (out_data_o.value !== expected_results[0].value) begin
          errors++;
          $display("%0t: value mismatch expected=%0d actual=%0d", $realtime,
                   expected_results[0].value, out_data_o.value);
        end
        if (out_data_o.last !== expected_results[0].last) begin
          errors++;
          $display("%0t: last mismatch expected=%0b actual=%0b", $realtime,
                   expected_results[0].last, out_data_o.last);
        end
        void'(expected_results.pop_front());
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_req && hold_count == 0) begin
      hold_count = 600;
      hold_req = 1'b0;
    end
    if (hold_count > 0) begin
      hold_count--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= !calm && $urandom_range(99) < 24;
    end
  end

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    case (idx)
      RegInRate: in_rate = 32'(data);
      RegOutRate: sym_rate = 32'(data);
      RegPhaseNudge: nudge = 32'(data[7:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (request_queue.size() == 0 && !offering && expected_results.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic add_sample(logic signed [15:0] value);
    in_item_t item;
    item.action = ActSample;
    item.sample = value;
    item.coef_phase = 6'($urandom);
    item.coef_tap = 4'($urandom);
    item.coef_value = 16'($urandom);
    request_queue.push_back(item);
  endtask

  task automatic add_coef(logic [5:0] row, logic [3:0] tap, logic signed [15:0] value);
    in_item_t item;
    item.action = ActCoef;
    item.sample = 16'($urandom);
    item.coef_phase = row;
    item.coef_tap = tap;
    item.coef_value = value;
    request_queue.push_back(item);
  endtask

  task automatic random_items(int count);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(9) == 0) add_coef(6'($urandom), 4'($urandom), 16'($urandom));
      else add_sample(16'($urandom));
    end
  endtask

  initial begin
    int unsigned in_list[5] = '{1, 65535, 1, 65535, 3000};
    int unsigned sym_list[5] = '{1, 65535, 16, 1, 7000};
    int unsigned nudge_list[5] = '{25, 255, 25, 0, 200};
    int counts[5] = '{30, 30, 20, 10, 40};
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegInRate;
    cfg_data_i = '0;
    offering = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_count = 0;
    errors = 0;
    samples_sent = 0;
    results_seen = 0;
    fill_level = 0;
    phase = 0;
    toggle = 1'b0;
    last_bit = 1'b0;
    older_bit = 1'b0;
    in_rate = 1;
    sym_rate = 1;
    nudge = 25;
    foreach (window[i]) window[i] = '0;
    foreach (tap_table[r, t]) tap_table[r][t] = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r <= NPhases; r++) begin
      for (int t = 0; t < NTaps; t++) add_coef(6'(r), 4'(t), 16'($urandom));
    end
    add_coef(6'd0, 4'd15, 16'sh7FFF);
    add_coef(6'd33, 4'd0, 16'sh1234);
    add_coef(6'd63, 4'd15, -16'sh8000);
    add_coef(6'd32, 4'd15, -16'sh8000);
    add_coef(6'd1, 4'd0, 16'sh7FFF);
    for (int k = 0; k < 16; k++) add_sample(k[0] ? 16'sh7FFF : -16'sh8000);
    add_sample('0);
    add_sample(-16'sh0001);
    add_sample(16'sh0001);

    for (int p = 0; p < 5; p++) begin
      wait_idle();
      write_reg(RegInRate, 16'(in_list[p]));
      write_reg(RegOutRate, 16'(sym_list[p]));
      write_reg(RegPhaseNudge, 16'(nudge_list[p]));
      calm = (p == 1);
      random_items(counts[p]);
      if (p == 2) begin
        wait (samples_sent > 0 && request_queue.size() < counts[p] - 3);
        hold_req = 1'b1;
      end
    end
    wait_idle();

    $display("Covered %0d samples and %0d results over five rate and nudge settings,",
             samples_sent, results_seen);
    $display("including a full tap table load, long output holds and ignored writes.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: polyphase_interpolator_timing_recovery.f
rtl/core/pitr_pkg.sv
rtl/core/pitr_div.sv
rtl/core/polyphase_interpolator_timing_recovery.sv
bench/testbench.sv
